@@ design/uncompressed_png_stream_encoder_unit_assert.svh @@
// Assertion macros shared by the encoder's RTL files.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef UNCOMPRESSED_PNG_STREAM_ENCODER_UNIT_ASSERT_SVH
`define UNCOMPRESSED_PNG_STREAM_ENCODER_UNIT_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define UPSE_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define UPSE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

@@ design/upse_pkg.sv @@
// Shared types and constants of the PNG stream encoder.
// No dependencies.
package upse_pkg;

  localparam int unsigned DimW = 13;

  localparam logic [DimW-1:0] MaxWidth  = 13'd4096;
  localparam logic [DimW-1:0] MaxHeight = 13'd4096;
  // Stored-block payload limit; the block count math relies on 2^16 - 1.
  localparam logic [15:0] BlockLimit = 16'hFFFF;

  localparam logic [DimW-1:0] WidthReset  = 13'd640;
  localparam logic [DimW-1:0] HeightReset = 13'd480;

  localparam logic KindStart = 1'b0;
  localparam logic KindPixel = 1'b1;

  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  typedef struct packed {
    logic            kind;
    logic            row_start;
    logic            last;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
    logic [7:0]      alpha;
    logic [DimW-1:0] fw;
    logic [DimW-1:0] fh;
  } cmd_t;

endpackage

@@ design/upse_front.sv @@
// Front end: config registers, frame position tracking, command classification.
// Depends on upse_pkg.
module upse_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [upse_pkg::DimW-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      kind_i,
  input  logic [7:0]                red_i,
  input  logic [7:0]                green_i,
  input  logic [7:0]                blue_i,
  input  logic [7:0]                alpha_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output upse_pkg::cmd_t            q_cmd_o
);

  logic [upse_pkg::DimW-1:0] width_q, height_q;
  logic [upse_pkg::DimW-1:0] fw_q, fh_q, col_q, row_q;
  logic [upse_pkg::DimW-1:0] fw_c, fh_c;
  logic                      active_q;
  logic                      accept_c, last_c;

  always_comb begin
    if (width_q == '0) fw_c = 13'd1;
    else if (width_q > upse_pkg::MaxWidth) fw_c = upse_pkg::MaxWidth;
    else fw_c = width_q;
    if (height_q == '0) fh_c = 13'd1;
    else if (height_q > upse_pkg::MaxHeight) fh_c = upse_pkg::MaxHeight;
    else fh_c = height_q;
  end

  assign in_stall_o = q_full_i;
  assign accept_c   = in_valid_i && !q_full_i;
  assign last_c     = (col_q == fw_q - 13'd1) && (row_q == fh_q - 13'd1);
  // Drop pixels outside a frame.
  assign q_push_o   = accept_c && (kind_i == upse_pkg::KindStart || active_q);

  always_comb begin
    q_cmd_o.kind      = kind_i;
    q_cmd_o.row_start = (col_q == '0);
    q_cmd_o.last      = last_c;
    q_cmd_o.red       = red_i;
    q_cmd_o.green     = green_i;
    q_cmd_o.blue      = blue_i;
    q_cmd_o.alpha     = alpha_i;
    q_cmd_o.fw        = fw_c;
    q_cmd_o.fh        = fh_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= upse_pkg::WidthReset;
      height_q <= upse_pkg::HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        upse_pkg::CfgWidth:  width_q  <= cfg_data_i;
        upse_pkg::CfgHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      fw_q     <= 13'd1;
      fh_q     <= 13'd1;
      col_q    <= '0;
      row_q    <= '0;
    end else if (accept_c) begin
      if (kind_i == upse_pkg::KindStart) begin
        active_q <= 1'b1;
        fw_q     <= fw_c;
        fh_q     <= fh_c;
        col_q    <= '0;
        row_q    <= '0;
      end else if (active_q) begin
        if (last_c) active_q <= 1'b0;
        if (col_q == fw_q - 13'd1) begin
          col_q <= '0;
          row_q <= row_q + 13'd1;
        end else begin
          col_q <= col_q + 13'd1;
        end
      end
    end
  end

endmodule

@@ design/upse_queue.sv @@
// Short command queue between front and back end.
// Depends on upse_pkg and the assertion macro header.
`include "uncompressed_png_stream_encoder_unit_assert.svh"
module upse_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  upse_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output upse_pkg::cmd_t cmd_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  upse_pkg::cmd_t      slot_q [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      if (pop_i)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (!push_i && pop_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  `UPSE_ASSERT(a_no_overflow, !(push_i && full_o), "queue push while full")
  `UPSE_ASSERT(a_no_underflow, !(pop_i && empty_o), "queue pop while empty")

endmodule

@@ design/upse_back.sv @@
// Back end: expands commands into PNG bytes, runs CRC-32 and Adler-32.
// Depends on upse_pkg and the assertion macro header; ends in a registered output stage.
`include "uncompressed_png_stream_encoder_unit_assert.svh"
module upse_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  upse_pkg::cmd_t q_cmd_i,
  input  logic           q_empty_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           run_last_o,
  output logic           frame_end_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_RAW   = 2'd2;
  localparam logic [1:0] ST_TRL   = 2'd3;

  localparam int unsigned RawW = 27;

  function automatic logic [31:0] crc8(logic [31:0] c_in, logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (32'hEDB88320 ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] be_byte(logic [31:0] v, logic [1:0] idx);
    logic [31:0] s;
    s = v >> ({3'd0, 2'd3 - idx} * 5'd8);
    return s[7:0];
  endfunction

  logic [1:0]      state_q;
  upse_pkg::cmd_t  cmd_q;
  logic [5:0]      step_q;
  logic [2:0]      ri_q, hi_q;
  logic [31:0]     crc_q, crc_d, crc_base;
  logic [15:0]     al_q, ah_q, al_d, ah_d;
  logic [16:0]     al_sum, ah_sum;
  logic [15:0]     blk_q;
  logic [RawW-1:0] rawl_q, rawt_q;
  logic [31:0]     idat_q;
  logic [27:0]     prod_c;
  logic [10:0]     blkq_c;
  logic [16:0]     blkr_c;
  logic [11:0]     blocks_c;
  logic [15:0]     len_c;
  logic            final_blk_c;

  logic       advance, fire;
  logic [7:0] byte_c;
  logic       in_crc_c, crc_rst_c, hdr_c, last_c, fend_c, to_trl_c;
  logic [5:0] off_c;

  logic       out_valid_q, out_last_q, out_fend_q;
  logic [7:0] out_byte_q;

  assign advance = !out_valid_q || !out_stall_i;
  assign fire    = (state_q != ST_IDLE) && advance;

  // Frame size math; settles well before the length bytes go out.
  assign prod_c   = {15'd0, cmd_q.fh} * {13'd0, cmd_q.fw, 2'b01};
  assign blkq_c   = rawt_q[26:16];
  assign blkr_c   = {1'b0, rawt_q[15:0]} + {6'd0, blkq_c};
  assign blocks_c = {1'b0, blkq_c} + {11'd0, blkr_c != '0} + {11'd0, blkr_c[16]};

  always_ff @(posedge clk_i) begin
    rawt_q <= prod_c[RawW-1:0];
    idat_q <= {5'd0, rawt_q} + {20'd0, blocks_c} * 32'd5 + 32'd6;
  end

  assign final_blk_c = (rawl_q <= {11'd0, upse_pkg::BlockLimit});
  assign len_c       = final_blk_c ? rawl_q[15:0] : upse_pkg::BlockLimit;

  always_comb begin
    byte_c    = 8'h00;
    in_crc_c  = 1'b0;
    crc_rst_c = 1'b0;
    hdr_c     = 1'b0;
    last_c    = 1'b0;
    fend_c    = 1'b0;
    to_trl_c  = 1'b0;
    off_c     = '0;
    unique case (state_q)
      ST_START: begin
        case (step_q) inside
          6'd0:  byte_c = 8'h89;
          6'd1:  byte_c = 8'h50;
          6'd2:  byte_c = 8'h4E;
          6'd3:  byte_c = 8'h47;
          6'd4:  byte_c = 8'h0D;
          6'd5:  byte_c = 8'h0A;
          6'd6:  byte_c = 8'h1A;
          6'd7:  byte_c = 8'h0A;
          6'd11: byte_c = 8'h0D;
          6'd12: byte_c = 8'h49;
          6'd13: byte_c = 8'h48;
          6'd14: byte_c = 8'h44;
          6'd15: byte_c = 8'h52;
          [6'd16:6'd19]: byte_c = be_byte({19'd0, cmd_q.fw}, step_q[1:0]);
          [6'd20:6'd23]: byte_c = be_byte({19'd0, cmd_q.fh}, step_q[1:0]);
          6'd24: byte_c = 8'h08;
          6'd25: byte_c = 8'h06;
          [6'd29:6'd32]: begin
            off_c  = step_q - 6'd29;
            byte_c = be_byte(~crc_q, off_c[1:0]);
          end
          [6'd33:6'd36]: begin
            off_c  = step_q - 6'd33;
            byte_c = be_byte(idat_q, off_c[1:0]);
          end
          6'd37: byte_c = 8'h49;
          6'd38: byte_c = 8'h44;
          6'd39: byte_c = 8'h41;
          6'd40: byte_c = 8'h54;
          6'd41: byte_c = 8'h78;
          6'd42: byte_c = 8'h01;
          default: byte_c = 8'h00;
        endcase
        in_crc_c  = (step_q >= 6'd12 && step_q <= 6'd28) || (step_q >= 6'd37);
        crc_rst_c = (step_q == 6'd12) || (step_q == 6'd37);
        last_c    = (step_q == 6'd42);
      end
      ST_RAW: begin
        in_crc_c = 1'b1;
        if (blk_q == '0) begin
          hdr_c = 1'b1;
          case (hi_q)
            3'd0:    byte_c = {7'd0, final_blk_c};
            3'd1:    byte_c = len_c[7:0];
            3'd2:    byte_c = len_c[15:8];
            3'd3:    byte_c = ~len_c[7:0];
            default: byte_c = ~len_c[15:8];
          endcase
        end else begin
          case (ri_q)
            3'd1:    byte_c = cmd_q.red;
            3'd2:    byte_c = cmd_q.green;
            3'd3:    byte_c = cmd_q.blue;
            3'd4:    byte_c = cmd_q.alpha;
            default: byte_c = 8'h00;
          endcase
          to_trl_c = (ri_q == 3'd4) && cmd_q.last;
          last_c   = (ri_q == 3'd4) && !cmd_q.last;
        end
      end
      ST_TRL: begin
        case (step_q) inside
          [6'd0:6'd3]: byte_c = be_byte({ah_q, al_q}, step_q[1:0]);
          [6'd4:6'd7]: byte_c = be_byte(~crc_q, step_q[1:0]);
          6'd12: byte_c = 8'h49;
          6'd13: byte_c = 8'h45;
          6'd14: byte_c = 8'h4E;
          6'd15: byte_c = 8'h44;
          [6'd16:6'd19]: byte_c = be_byte(~crc_q, step_q[1:0]);
          default: byte_c = 8'h00;
        endcase
        in_crc_c  = (step_q <= 6'd3) || (step_q >= 6'd12 && step_q <= 6'd15);
        crc_rst_c = (step_q == 6'd12);
        last_c    = (step_q == 6'd19);
        fend_c    = last_c;
      end
      default: ;
    endcase
  end

  assign crc_base = crc_rst_c ? 32'hFFFFFFFF : crc_q;
  assign crc_d    = in_crc_c ? crc8(crc_base, byte_c) : crc_base;

  // Adler-32 over raw bytes: two mod-65521 adds.
  assign al_sum = {1'b0, al_q} + {9'd0, byte_c};
  assign al_d   = (al_sum >= 17'd65521) ? 16'(al_sum - 17'd65521) : al_sum[15:0];
  assign ah_sum = {1'b0, ah_q} + {1'b0, al_d};
  assign ah_d   = (ah_sum >= 17'd65521) ? 16'(ah_sum - 17'd65521) : ah_sum[15:0];

  assign q_pop_o = !q_empty_i && ((state_q == ST_IDLE) || (fire && last_c));

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cmd_q <= q_cmd_i;
  end

  // Checksums and block counters step only on the emitted bytes they cover.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= 32'hFFFFFFFF;
      al_q   <= 16'd1;
      ah_q   <= '0;
      blk_q  <= '0;
      rawl_q <= '0;
    end else if (fire) begin
      crc_q <= crc_d;
      unique case (state_q)
        ST_START: begin
          if (last_c) begin
            al_q   <= 16'd1;
            ah_q   <= '0;
            blk_q  <= '0;
            rawl_q <= rawt_q;
          end
        end
        ST_RAW: begin
          if (hdr_c) begin
            if (hi_q == 3'd4) blk_q <= len_c;
          end else begin
            al_q   <= al_d;
            ah_q   <= ah_d;
            blk_q  <= blk_q - 16'd1;
            rawl_q <= rawl_q - RawW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Sequencing; a pop loads the next command over the last byte of the current one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      ri_q    <= '0;
      hi_q    <= '0;
    end else if (q_pop_o) begin
      state_q <= (q_cmd_i.kind == upse_pkg::KindStart) ? ST_START : ST_RAW;
      step_q  <= '0;
      hi_q    <= '0;
      ri_q    <= q_cmd_i.row_start ? 3'd0 : 3'd1;
    end else if (fire) begin
      unique case (state_q)
        ST_START: step_q <= step_q + 6'd1;
        ST_RAW: begin
          if (hdr_c) hi_q <= (hi_q == 3'd4) ? '0 : hi_q + 3'd1;
          else ri_q <= ri_q + 3'd1;
          if (to_trl_c) begin
            state_q <= ST_TRL;
            step_q  <= '0;
          end
        end
        ST_TRL: step_q <= step_q + 6'd1;
        default: ;
      endcase
      if (last_c) state_q <= ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q <= byte_c;
      out_last_q <= last_c;
      out_fend_q <= fend_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = out_last_q;
  assign frame_end_o = out_fend_q;

  `UPSE_ASSERT(a_fend_is_last, !(out_valid_q && out_fend_q) || out_last_q, "frame end without run last")
  `UPSE_ASSERT(a_hdr_on_empty, !(state_q == ST_RAW && hi_q != '0) || blk_q == '0, "block header mid block")
  `UPSE_ASSERT_NEXT(a_start_load, q_pop_o && q_cmd_i.kind == upse_pkg::KindStart, state_q == ST_START && step_q == '0, "start not loaded")

endmodule

@@ design/uncompressed_png_stream_encoder_unit.sv @@
// PNG stream encoder top level: front end, command queue, back end.
// Depends on upse_pkg, upse_front, upse_queue, upse_back.
//
// Usage:
//   Input beats (valid/stall) carry kind plus an RGBA pixel. A start beat
//   (kind 0) produces the 43-byte file head: signature, IHDR, IDAT length and
//   type, zlib header. Each pixel beat produces its four bytes, preceded by a
//   filter byte at row start, with a five-byte stored-block header put in
//   wherever a block opens; the frame's final pixel adds the 20-byte trailer.
//   Pixels outside a frame are dropped. The user writes width and height
//   through the config port while idle; the block does not enforce this.
//   Both are taken at the start beat. Output beats carry one byte each;
//   run_last marks an input beat's last byte, frame_end the file's final byte.
// Timing:
//   When the back end is idle, an accepted beat is written to the queue, then
//   loaded into the back end's command register, and its first byte is then
//   registered in the output stage. The back end emits one byte per cycle
//   while it has a command and its output is not stalled. The queue of
//   Depth commands lets input beats be taken while earlier ones are still
//   being expanded. A stalled output holds its byte; once the queue fills,
//   in_stall_o rises. Reset clears the frame state, the queue and the output
//   stage and loads the default size of 640 by 480.
module uncompressed_png_stream_encoder_unit #(
  parameter int unsigned Depth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  alpha_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        frame_end_o
);

  upse_pkg::cmd_t push_cmd, head_cmd;
  logic           push, pop, full, empty;

  upse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .alpha_i     (alpha_i),
    .q_full_i    (full),
    .q_push_o    (push),
    .q_cmd_o     (push_cmd)
  );

  upse_queue #(.Depth(Depth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  upse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_cmd_i     (head_cmd),
    .q_empty_i   (empty),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .frame_end_o (frame_end_o)
  );

endmodule

@@ tb/sv/png_stream_checker.sv @@
// Stream checker for the PNG encoder: predicts the byte stream of every input beat
// and compares it with the output channel. Depends on upse_pkg.
`timescale 1ns / 100ps
module png_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        kind_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  alpha_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  out_byte_i,
  input  logic        run_last_i,
  input  logic        frame_end_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int BeatCap = 43;

  typedef enum logic [1:0] {PhIdle, PhFrame, PhDone} phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       frame_end;
  } png_byte_t;

  png_byte_t png_bytes_due[$];
  png_byte_t beat_bytes[$];

  logic [12:0]     width_reg, height_reg;
  logic [12:0]     frame_w, frame_h;
  logic [31:0]     crc;
  logic [15:0]     adler_lo, adler_hi;
  logic [12:0]     col;
  logic [16:0]     block_left;
  longint unsigned raw_left;
  phase_e          phase;
  int              mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = png_bytes_due.size();

  function automatic logic [12:0] clamp_dim(logic [12:0] v, logic [12:0] m);
    if (v == 0) return 13'd1;
    return (v > m) ? m : v;
  endfunction

  task automatic emit(input logic [7:0] b, input logic is_end);
    png_byte_t e;
    e.data = b;
    e.run_last = 1'b0;
    e.frame_end = is_end;
    if (beat_bytes.size() < BeatCap) beat_bytes.insert(beat_bytes.size(), e);
  endtask

  task automatic crc_emit(input logic [7:0] b, input logic is_end);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? (32'hEDB88320 ^ (c >> 1)) : (c >> 1);
    crc = c;
    emit(b, is_end);
  endtask

  task automatic be32(input logic [31:0] v, input bit in_crc, input bit is_end);
    logic [7:0] b;
    for (int s = 3; s >= 0; s--) begin
      b = v[s*8 +: 8];
      if (in_crc) crc_emit(b, is_end && s == 0);
      else emit(b, is_end && s == 0);
    end
  endtask

  task automatic scan_byte(input logic [7:0] b);
    longint unsigned len;
    logic [15:0] inv;
    logic [16:0] lo_sum;
    if (raw_left == 0) return;
    if (block_left == 0) begin
      len = (raw_left < upse_pkg::BlockLimit) ? raw_left : upse_pkg::BlockLimit;
      inv = ~len[15:0];
      crc_emit({7'd0, raw_left <= upse_pkg::BlockLimit}, 1'b0);
      crc_emit(len[7:0], 1'b0);
      crc_emit(len[15:8], 1'b0);
      crc_emit(inv[7:0], 1'b0);
      crc_emit(inv[15:8], 1'b0);
      block_left = len[16:0];
    end
    crc_emit(b, 1'b0);
    lo_sum = {1'b0, adler_lo} + {9'd0, b};
    if (lo_sum >= 17'd65521) lo_sum = lo_sum - 17'd65521;
    adler_lo = lo_sum[15:0];
    adler_hi = (32'(adler_hi) + adler_lo >= 65521) ? adler_hi + adler_lo - 16'd65521
                                                    : adler_hi + adler_lo;
    block_left--;
    raw_left--;
  endtask

  task automatic open_frame();
    longint unsigned raw, blocks, idat_len;
    logic [7:0] sig [8];
    sig = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    frame_w = clamp_dim(width_reg, upse_pkg::MaxWidth);
    frame_h = clamp_dim(height_reg, upse_pkg::MaxHeight);
    raw = longint'(frame_h) * (longint'(frame_w) * 4 + 1);
    blocks = (raw + upse_pkg::BlockLimit - 1) / upse_pkg::BlockLimit;
    idat_len = 2 + raw + 5 * blocks + 4;
    for (int i = 0; i < 8; i++) emit(sig[i], 1'b0);
    be32(32'd13, 0, 0);
    crc = '1;
    be32("IHDR", 1, 0);
    be32({19'd0, frame_w}, 1, 0);
    be32({19'd0, frame_h}, 1, 0);
    crc_emit(8'd8, 0);
    crc_emit(8'd6, 0);
    crc_emit(8'd0, 0);
    crc_emit(8'd0, 0);
    crc_emit(8'd0, 0);
    be32(~crc, 0, 0);
    be32(idat_len[31:0], 0, 0);
    crc = '1;
    be32("IDAT", 1, 0);
    crc_emit(8'h78, 0);
    crc_emit(8'h01, 0);
    adler_lo = 16'd1;
    adler_hi = '0;
    col = '0;
    block_left = '0;
    raw_left = raw;
    phase = PhFrame;
  endtask

  task automatic close_frame();
    be32({adler_hi, adler_lo}, 1, 0);
    be32(~crc, 0, 0);
    be32(32'd0, 0, 0);
    crc = '1;
    be32("IEND", 1, 0);
    be32(~crc, 0, 1);
    phase = PhDone;
  endtask

  task automatic encode_beat(input logic kind, input logic [31:0] rgba);
    beat_bytes.delete();
    if (kind == upse_pkg::KindStart) begin
      open_frame();
    end else if (phase == PhFrame) begin
      if (col == 0) scan_byte(8'd0);
      for (int i = 3; i >= 0; i--) scan_byte(rgba[i*8 +: 8]);
      col++;
      if (col >= frame_w) col = '0;
      if (raw_left == 0) close_frame();
    end
    if (beat_bytes.size() > 0) beat_bytes[beat_bytes.size()-1].run_last = 1'b1;
    foreach (beat_bytes[i]) png_bytes_due.insert(png_bytes_due.size(), beat_bytes[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    png_byte_t want;
    if (!rst_ni) begin
      png_bytes_due.delete();
      width_reg  = upse_pkg::WidthReset;
      height_reg = upse_pkg::HeightReset;
      frame_w = 13'd1;
      frame_h = 13'd1;
      crc = '1;
      adler_lo = 16'd1;
      adler_hi = '0;
      col = '0;
      block_left = '0;
      raw_left = 0;
      phase = PhIdle;
      mismatches = 0;
    end else begin
      // outputs first: a beat taken at this edge cannot show up at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (png_bytes_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: byte %02h with nothing pending", $realtime, out_byte_i);
          mismatches++;
        end else begin
          want = png_bytes_due.pop_front();
          if (want.data !== out_byte_i || want.run_last !== run_last_i ||
              want.frame_end !== frame_end_i) begin
            if (mismatches < 10)
              $display("%0t: expected byte %02h last %b end %b, got %02h last %b end %b",
                       $realtime, want.data, want.run_last, want.frame_end,
                       out_byte_i, run_last_i, frame_end_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        encode_beat(kind_i, {red_i, green_i, blue_i, alpha_i});
      if (cfg_we_i) begin
        if (cfg_index_i == upse_pkg::CfgWidth) width_reg = cfg_data_i;
        else height_reg = cfg_data_i;
      end
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the PNG encoder testbench: clock, reset, stimulus, output stalls, verdict.
// Depends on upse_pkg, uncompressed_png_stream_encoder_unit and png_stream_checker.
`timescale 1ns / 100ps
module testbench;

  localparam int CycleLimit = 3000000;

  logic        clk_i, rst_ni;
  logic        cfg_we_i, cfg_index_i;
  logic [12:0] cfg_data_i;
  logic        in_valid_i, in_stall_o, kind_i;
  logic [7:0]  red_i, green_i, blue_i, alpha_i;
  logic        out_valid_o, out_stall_i;
  logic [7:0]  out_byte_o;
  logic        run_last_o, frame_end_o;
  int          fail_count, pending;

  logic        tx_idle_en, rx_idle_en, hold_toggle, hold_seen;
  int          rx_wait, cycles;
  int          cur_w, cur_h, pixels_sent;

  uncompressed_png_stream_encoder_unit u_dut (.*);

  png_stream_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .red_i, .green_i, .blue_i, .alpha_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_byte_i(out_byte_o),
    .run_last_i(run_last_o), .frame_end_i(frame_end_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: while rx_idle_en is set, a random, possibly empty stall before each beat, plus a long hold on request.
  always @(posedge clk_i or negedge rst_ni) begin
    int n;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait <= 0;
      hold_seen <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      rx_wait <= 300;
      out_stall_i <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_stall_i <= 1'b1;
    end else if (out_valid_o && !out_stall_i && rx_idle_en) begin
      n = $urandom_range(0, 8);
      out_stall_i <= (n > 0);
      rx_wait <= (n > 0) ? n - 1 : 0;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_beat(input logic kind, input logic [31:0] rgba);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    {red_i, green_i, blue_i, alpha_i} <= rgba;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [12:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == upse_pkg::CfgWidth)
      cur_w = (val == 0) ? 1 : (val > upse_pkg::MaxWidth ? upse_pkg::MaxWidth : val);
    else
      cur_h = (val == 0) ? 1 : (val > upse_pkg::MaxHeight ? upse_pkg::MaxHeight : val);
  endtask

  // Hold the sender until every pending byte is out, then let dropped beats settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_frame(input bit abort, input bit extra);
    int n;
    send_beat(upse_pkg::KindStart, $urandom());
    n = cur_w * cur_h;
    if (abort) n = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) send_beat(upse_pkg::KindPixel, $urandom());
    pixels_sent += n + 1;
    if (extra) send_beat(upse_pkg::KindPixel, $urandom());
  endtask

  initial begin
    int frame_no;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= upse_pkg::CfgWidth;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    kind_i <= upse_pkg::KindPixel;
    {red_i, green_i, blue_i, alpha_i} <= '0;
    tx_idle_en <= 1'b1;
    rx_idle_en <= 1'b1;
    hold_toggle <= 1'b0;
    cur_w = upse_pkg::WidthReset;
    cur_h = upse_pkg::HeightReset;
    pixels_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: drop while idle, default size, abandon, clamps, write mid-frame
    send_beat(upse_pkg::KindPixel, 32'hA5A5A5A5);
    send_beat(upse_pkg::KindStart, 32'h0);
    send_beat(upse_pkg::KindPixel, 32'h00000000);
    send_beat(upse_pkg::KindPixel, 32'hFFFFFFFF);
    drain();
    write_reg(upse_pkg::CfgWidth, 13'd0);
    write_reg(upse_pkg::CfgHeight, 13'd0);
    send_beat(upse_pkg::KindPixel, 32'h12345678);
    send_beat(upse_pkg::KindStart, 32'hFFFFFFFF);
    send_beat(upse_pkg::KindPixel, 32'hFFFFFFFF);
    send_beat(upse_pkg::KindPixel, 32'h5A5A5A5A);
    drain();
    write_reg(upse_pkg::CfgWidth, 13'h1FFF);
    write_reg(upse_pkg::CfgHeight, 13'd4097);
    send_beat(upse_pkg::KindStart, 32'h0);
    drain();
    write_reg(upse_pkg::CfgWidth, 13'd2);
    write_reg(upse_pkg::CfgHeight, 13'd2);
    send_beat(upse_pkg::KindStart, 32'h0);
    send_beat(upse_pkg::KindPixel, 32'h01020304);
    drain();
    write_reg(upse_pkg::CfgWidth, 13'd3);
    send_beat(upse_pkg::KindPixel, 32'hFEDCBA98);
    send_beat(upse_pkg::KindPixel, 32'h80808080);
    send_beat(upse_pkg::KindPixel, 32'h7F7F7F7F);
    send_beat(upse_pkg::KindPixel, 32'hC3C3C3C3);
    drain();

    pixels_sent = 0;
    frame_no = 0;
    write_reg(upse_pkg::CfgWidth, 13'd3);
    write_reg(upse_pkg::CfgHeight, 13'd2);
    while (pixels_sent < 430) begin
      if ($urandom_range(0, 99) < 25) begin
        drain();
        write_reg(upse_pkg::CfgWidth,
                  ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 6)));
        write_reg(upse_pkg::CfgHeight,
                  ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 4)));
      end
      tx_idle_en <= ($urandom_range(0, 3) != 0);
      rx_idle_en <= ($urandom_range(0, 3) != 0);
      if (frame_no == 6 || frame_no == 30) hold_toggle <= ~hold_toggle;
      if ($urandom_range(0, 19) == 0) send_beat(upse_pkg::KindPixel, $urandom());
      send_frame($urandom_range(0, 9) == 0, $urandom_range(0, 4) == 0);
      frame_no++;
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
